@@ design/gre_pkg.sv @@
// Shared types and constants for the graph reachability engine.
// Used by gre_ctrl, gre_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gre_pkg;

  localparam int GRE_MAX_NODES = 16;
  localparam int GRE_MULT_BITS = 4;
  localparam int NODE_W        = 5;
  localparam int MODE_W        = 2;
  localparam int STATUS_W      = 2;

  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 5'd10;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK     = 2'd0,
    STS_RANGE  = 2'd1,
    STS_ABSENT = 2'd2,
    STS_SAT    = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_SWEEP_REQ,
    ST_IDLE,
    ST_DECODE,
    ST_RMW,
    ST_POP,
    ST_POP_WAIT,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic    req_load;
    logic    sweep_start;
    logic    sweep_we;
    logic    edge_rd;
    logic    rmw_inc;
    logic    rmw_dec;
    logic    q_init;
    logic    pop;
    logic    scan;
    logic    set_res;
    status_e res_status;
    logic    res_reach;
    logic    out_load;
  } gre_cmd_t;

  typedef struct packed {
    mode_e req_mode;
    logic  req_bad;
    logic  sweep_last;
    logic  mult_full;
    logic  mult_zero;
    logic  stack_empty;
    logic  hit;
    logic  scan_done;
    logic  out_free;
  } gre_sts_t;

endpackage

`default_nettype wire

@@ design/graph_reachability_engine_unit.sv @@
// Graph reachability engine top level: gre_ctrl sequencer plus gre_datapath.
// A query pops nodes off a search stack and scans each popped node's edges.
// One item at a time; a clear request sweeps 2**(2*clog2(MAX_NODES)) entries (256)
// before its result is valid.
// Reset (async, active low) and each node_count write start that same clearing
// sweep, one edge entry a cycle, during which in_stall_o stays high.
`timescale 1ns / 1ps
`default_nettype none

module graph_reachability_engine_unit #(
  parameter int MAX_NODES = gre_pkg::GRE_MAX_NODES,
  parameter int MULT_BITS = gre_pkg::GRE_MULT_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [gre_pkg::NODE_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [gre_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [gre_pkg::NODE_W-1:0]   from_node_i,
  input  wire logic [gre_pkg::NODE_W-1:0]   to_node_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [gre_pkg::STATUS_W-1:0]      status_o,
  output logic                              reachable_o
);
  import gre_pkg::*;

  gre_cmd_t cmd;
  gre_sts_t sts;

  gre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cfg_we_i   (cfg_we_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  gre_datapath #(
    .MAX_NODES (MAX_NODES),
    .MULT_BITS (MULT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mode_i      (mode_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .reachable_o (reachable_o)
  );

`ifndef SYNTHESIS
  a_sweep_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.sweep_we |-> in_stall_o)
    else $error("item accepted during edge clearing sweep");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second item accepted while one is in work");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("result load did not raise out_valid_o");

  a_reach_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> (!reachable_o || (status_o == STS_OK)))
    else $error("reachable set on a failed request");
`endif

endmodule

`default_nettype wire

@@ design/gre_ctrl.sv @@
// Sequencer for the graph reachability engine: request decode, clearing
// sweep, read-modify-write of edge counts and the depth-first search steps.
// Depends on gre_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gre_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             cfg_we_i,
  input  gre_pkg::gre_sts_t     sts_i,
  output gre_pkg::gre_cmd_t     cmd_o,
  output logic                  in_stall_o
);
  import gre_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_SWEEP: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_SWEEP_REQ: begin
        if (sts_i.sweep_last) state_d = ST_OUT;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (sts_i.req_mode == MODE_CLEAR) begin
          state_d = ST_SWEEP_REQ;
        end else if (sts_i.req_bad) begin
          state_d = ST_OUT;
        end else if (sts_i.req_mode == MODE_QUERY) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_RMW;
        end
      end
      ST_RMW: begin
        state_d = ST_OUT;
      end
      ST_POP: begin
        state_d = sts_i.stack_empty ? ST_OUT : ST_POP_WAIT;
      end
      ST_POP_WAIT: begin
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          state_d = ST_OUT;
        end else if (sts_i.scan_done) begin
          state_d = ST_POP;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // a node count write restarts the clearing sweep
    if (cfg_we_i) state_d = ST_SWEEP;
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.res_status  = STS_OK;
    cmd_o.sweep_start = cfg_we_i;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep_we = 1'b1;
      end
      ST_SWEEP_REQ: begin
        cmd_o.sweep_we = 1'b1;
        cmd_o.set_res  = sts_i.sweep_last;
      end
      ST_IDLE: begin
        cmd_o.req_load = in_valid_i;
      end
      ST_DECODE: begin
        if (sts_i.req_mode == MODE_CLEAR) begin
          cmd_o.sweep_start = 1'b1;
        end else if (sts_i.req_bad) begin
          cmd_o.set_res    = 1'b1;
          cmd_o.res_status = STS_RANGE;
        end else if (sts_i.req_mode == MODE_QUERY) begin
          cmd_o.q_init = 1'b1;
        end else begin
          cmd_o.edge_rd = 1'b1;
        end
      end
      ST_RMW: begin
        cmd_o.set_res = 1'b1;
        if (sts_i.req_mode == MODE_INSERT) begin
          if (sts_i.mult_full) begin
            cmd_o.res_status = STS_SAT;
          end else begin
            cmd_o.rmw_inc = 1'b1;
          end
        end else begin
          if (sts_i.mult_zero) begin
            cmd_o.res_status = STS_ABSENT;
          end else begin
            cmd_o.rmw_dec = 1'b1;
          end
        end
      end
      ST_POP: begin
        if (sts_i.stack_empty) begin
          cmd_o.set_res = 1'b1;
        end else begin
          cmd_o.pop = 1'b1;
        end
      end
      ST_POP_WAIT: begin
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.hit) begin
          cmd_o.set_res   = 1'b1;
          cmd_o.res_reach = 1'b1;
        end
      end
      ST_OUT: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

@@ design/gre_datapath.sv @@
// Datapath of the graph reachability engine: node count register, edge
// count memory, search stack memory, visited marks and result registers.
// Depends on gre_pkg; driven by gre_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module gre_datapath #(
  parameter int MAX_NODES = gre_pkg::GRE_MAX_NODES,
  parameter int MULT_BITS = gre_pkg::GRE_MULT_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gre_pkg::NODE_W-1:0]    cfg_wdata_i,
  input  wire logic [gre_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [gre_pkg::NODE_W-1:0]    from_node_i,
  input  wire logic [gre_pkg::NODE_W-1:0]    to_node_i,
  input  wire logic                          out_stall_i,
  input  gre_pkg::gre_cmd_t                  cmd_i,
  output gre_pkg::gre_sts_t                  sts_o,
  output logic                               out_valid_o,
  output logic [gre_pkg::STATUS_W-1:0]       status_o,
  output logic                               reachable_o
);
  import gre_pkg::*;

  localparam int IW         = $clog2(MAX_NODES);
  localparam int AW         = 2 * IW;
  localparam int EDGE_DEPTH = 2 ** AW;

  // configuration
  logic [NODE_W-1:0] node_count_q;
  logic [IW:0]       n_act;
  logic [IW:0]       n_m1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      node_count_q <= cfg_wdata_i;
    end
  end

  assign n_act = (int'(node_count_q) > MAX_NODES) ? (IW+1)'(MAX_NODES)
                                                  : (IW+1)'(node_count_q);
  assign n_m1  = n_act - (IW+1)'(1);

  // request registers
  mode_e             mode_q;
  logic              bad_q;
  logic [IW-1:0]     s_q;
  logic [IW-1:0]     d_q;
  logic              bad_d;
  logic [NODE_W-1:0] from_m1;
  logic [NODE_W-1:0] to_m1;

  assign bad_d   = (from_node_i == '0) || (to_node_i == '0) ||
                   (from_node_i > n_act) || (to_node_i > n_act);
  assign from_m1 = from_node_i - NODE_W'(1);
  assign to_m1   = to_node_i - NODE_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      mode_q <= mode_e'(mode_i);
      bad_q  <= bad_d;
      s_q    <= IW'(from_m1);
      d_q    <= IW'(to_m1);
    end
  end

  // clearing sweep
  logic [AW-1:0] sweep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_start) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep_we) begin
      sweep_q <= sweep_q + AW'(1);
    end
  end

  // edge count memory
  logic [MULT_BITS-1:0] edge_mem [EDGE_DEPTH];
  logic [MULT_BITS-1:0] edge_rdata_q;
  logic                 edge_we;
  logic                 edge_re;
  logic [AW-1:0]        edge_waddr;
  logic [AW-1:0]        edge_raddr;
  logic [MULT_BITS-1:0] edge_wdata;

  // search state
  logic [IW-1:0]        stack_mem [MAX_NODES];
  logic [IW-1:0]        stack_rdata_q;
  logic [IW:0]          sp_q, sp_d;
  logic [IW:0]          sp_m1;
  logic [IW:0]          v_q, v_d;
  logic                 chk_valid_q, chk_valid_d;
  logic [IW-1:0]        chk_v_q;
  logic [MAX_NODES-1:0] visited_q, visited_d;
  logic                 scan_issue;
  logic                 edge_nz;
  logic                 hit;
  logic                 push;
  logic                 stack_we;
  logic [IW-1:0]        stack_waddr;
  logic [IW-1:0]        stack_wdata;

  assign scan_issue = cmd_i.scan && (v_q < n_act);
  assign edge_nz    = (edge_rdata_q != '0);
  assign hit        = chk_valid_q && edge_nz && (chk_v_q == d_q);
  assign push       = cmd_i.scan && chk_valid_q && edge_nz && !hit &&
                      !visited_q[chk_v_q] && (sp_q < (IW+1)'(MAX_NODES));

  assign edge_we    = cmd_i.sweep_we || cmd_i.rmw_inc || cmd_i.rmw_dec;
  assign edge_waddr = cmd_i.sweep_we ? sweep_q : {s_q, d_q};
  assign edge_wdata = cmd_i.sweep_we ? '0 :
                      cmd_i.rmw_inc  ? edge_rdata_q + MULT_BITS'(1)
                                     : edge_rdata_q - MULT_BITS'(1);
  assign edge_re    = cmd_i.edge_rd || scan_issue;
  assign edge_raddr = cmd_i.edge_rd ? {s_q, d_q} : {stack_rdata_q, v_q[IW-1:0]};

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    if (edge_re) edge_rdata_q <= edge_mem[edge_raddr];
  end

  assign sp_m1       = sp_q - (IW+1)'(1);
  assign stack_we    = cmd_i.q_init || push;
  assign stack_waddr = cmd_i.q_init ? '0 : sp_q[IW-1:0];
  assign stack_wdata = cmd_i.q_init ? s_q : chk_v_q;

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    if (cmd_i.pop) stack_rdata_q <= stack_mem[sp_m1[IW-1:0]];
  end

  always_comb begin
    sp_d        = sp_q;
    v_d         = v_q;
    chk_valid_d = chk_valid_q;
    visited_d   = visited_q;
    if (cmd_i.q_init) begin
      sp_d           = (IW+1)'(1);
      visited_d      = '0;
      visited_d[s_q] = 1'b1;
    end else if (cmd_i.pop) begin
      sp_d        = sp_m1;
      v_d         = '0;
      chk_valid_d = 1'b0;
    end else if (cmd_i.scan) begin
      chk_valid_d = scan_issue;
      if (scan_issue) v_d = v_q + (IW+1)'(1);
      if (push) begin
        sp_d               = sp_q + (IW+1)'(1);
        visited_d[chk_v_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      v_q         <= '0;
      chk_valid_q <= 1'b0;
      visited_q   <= '0;
    end else begin
      sp_q        <= sp_d;
      v_q         <= v_d;
      chk_valid_q <= chk_valid_d;
      visited_q   <= visited_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_issue) chk_v_q <= v_q[IW-1:0];
  end

  // result and output registers
  status_e              res_status_q;
  logic                 res_reach_q;
  logic                 out_valid_q;
  logic [STATUS_W-1:0]  out_status_q;
  logic                 out_reach_q;
  logic                 out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_res) begin
      res_status_q <= cmd_i.res_status;
      res_reach_q  <= cmd_i.res_reach;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_reach_q  <= res_reach_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign reachable_o = out_reach_q;

  always_comb begin
    sts_o             = '0;
    sts_o.req_mode    = mode_q;
    sts_o.req_bad     = bad_q;
    sts_o.sweep_last  = &sweep_q;
    sts_o.mult_full   = &edge_rdata_q;
    sts_o.mult_zero   = !edge_nz;
    sts_o.stack_empty = (sp_q == '0);
    sts_o.hit         = hit;
    sts_o.scan_done   = chk_valid_q && ({1'b0, chk_v_q} == n_m1);
    sts_o.out_free    = out_free;
  end

endmodule

`default_nettype wire

@@ tb/sv/tb_graph_reachability_engine_unit.sv @@
// Self-checking testbench for graph_reachability_engine_unit: edge insert/delete,
// clear and reachability items against an in-bench graph predictor, random idling.
// Depends on gre_pkg and the graph_reachability_engine_unit RTL.
`timescale 1ns / 1ps

module tb_graph_reachability_engine_unit;
  import gre_pkg::*;

  typedef struct packed {
    status_e status;
    logic    reach;
  } graph_result_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [NODE_W-1:0]   cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [MODE_W-1:0]   mode_i      = '0;
  logic [NODE_W-1:0]   from_node_i = '0;
  logic [NODE_W-1:0]   to_node_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic                reachable_o;

  // predicted graph state
  logic [GRE_MULT_BITS-1:0] edge_count [GRE_MAX_NODES][GRE_MAX_NODES];
  logic [NODE_W-1:0]        node_count_cfg;

  graph_result_t pending_results [$];
  graph_result_t next_result;
  bit            quiet_stretch = 1'b0;
  int            mismatches, items_sent, results_checked, reach_hits, cfg_writes;
  int            status_seen [4];

  graph_reachability_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .from_node_i (from_node_i),
    .to_node_i   (to_node_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .reachable_o (reachable_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !quiet_stretch && ($urandom_range(0, 99) < 16);
  end

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  function automatic void clear_graph();
    foreach (edge_count[i, j]) edge_count[i][j] = '0;
  endfunction

  function automatic int active_nodes();
    return (node_count_cfg > GRE_MAX_NODES) ? GRE_MAX_NODES : int'(node_count_cfg);
  endfunction

  // depth-first search, one or more edges from src to dst (0-based)
  function automatic bit path_exists(int src, int dst, int n);
    bit seen [GRE_MAX_NODES];
    int stack [GRE_MAX_NODES];
    int depth;
    int u;
    foreach (seen[i]) seen[i] = 1'b0;
    depth      = 1;
    seen[src]  = 1'b1;
    stack[0]   = src;
    while (depth > 0) begin
      depth = depth - 1;
      u     = stack[depth];
      for (int v = 0; v < n; v++) begin
        if (edge_count[u][v] != '0) begin
          if (v == dst) return 1'b1;
          if (!seen[v] && depth < GRE_MAX_NODES) begin
            seen[v]      = 1'b1;
            stack[depth] = v;
            depth        = depth + 1;
          end
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic graph_result_t apply_request(mode_e m, logic [NODE_W-1:0] f,
                                                  logic [NODE_W-1:0] t);
    graph_result_t r;
    int n;
    int s;
    int d;
    n        = active_nodes();
    r.status = STS_OK;
    r.reach  = 1'b0;
    if (m == MODE_CLEAR) begin
      clear_graph();
    end else if (f == 0 || t == 0 || f > n || t > n) begin
      r.status = STS_RANGE;
    end else begin
      s = int'(f) - 1;
      d = int'(t) - 1;
      case (m)
        MODE_INSERT: begin
          if (edge_count[s][d] == {GRE_MULT_BITS{1'b1}}) r.status = STS_SAT;
          else edge_count[s][d] = edge_count[s][d] + GRE_MULT_BITS'(1);
        end
        MODE_DELETE: begin
          if (edge_count[s][d] == '0) r.status = STS_ABSENT;
          else edge_count[s][d] = edge_count[s][d] - GRE_MULT_BITS'(1);
        end
        default: begin
          r.reach = path_exists(s, d, n);
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with no request pending");
      end else begin
        next_result = pending_results.pop_front();
        results_checked++;
        status_seen[next_result.status]++;
        if (next_result.reach) reach_hits++;
        if (status_o !== next_result.status)
          report_mismatch($sformatf("status %0d, predicted %0d", status_o,
                                    next_result.status));
        if (reachable_o !== next_result.reach)
          report_mismatch($sformatf("reachable %0b, predicted %0b", reachable_o,
                                    next_result.reach));
      end
    end
  end

  task automatic send_request(mode_e m, logic [NODE_W-1:0] f, logic [NODE_W-1:0] t);
    while (!quiet_stretch && $urandom_range(0, 99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= m;
    from_node_i <= f;
    to_node_i   <= t;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    pending_results.push_back(apply_request(m, f, t));
    items_sent++;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    wait_drained();
  endtask

  // write only with the input side idle and nothing outstanding
  task automatic set_node_count(logic [NODE_W-1:0] v);
    wait_drained();
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    node_count_cfg = v;
    clear_graph();
    cfg_writes++;
  endtask

  task automatic run_mixed_traffic(int count);
    int n;
    int pick;
    mode_e m;
    logic [NODE_W-1:0] f;
    logic [NODE_W-1:0] t;
    n = active_nodes();
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (n == 0 || pick < 8) begin
        m = mode_e'($urandom_range(0, 2));
        f = NODE_W'($urandom_range(0, 31));
        t = NODE_W'($urandom_range(0, 31));
      end else begin
        f = NODE_W'($urandom_range(1, n));
        t = NODE_W'($urandom_range(1, n));
        if (pick < 11) begin
          m = MODE_CLEAR;
          f = NODE_W'($urandom_range(0, 31));
          t = NODE_W'($urandom_range(0, 31));
        end else if (pick < 52) begin
          m = MODE_INSERT;
        end else if (pick < 70) begin
          m = MODE_DELETE;
        end else begin
          m = MODE_QUERY;
        end
      end
      send_request(m, f, t);
    end
  endtask

  // reset node count of ten: short paths, self query with and without a cycle
  task automatic test_default_graph();
    send_request(MODE_INSERT, 5'd1, 5'd2);
    send_request(MODE_INSERT, 5'd2, 5'd3);
    send_request(MODE_QUERY,  5'd1, 5'd3);
    send_request(MODE_QUERY,  5'd3, 5'd1);
    send_request(MODE_QUERY,  5'd1, 5'd1);
    send_request(MODE_INSERT, 5'd3, 5'd1);
    send_request(MODE_QUERY,  5'd1, 5'd1);
    send_request(MODE_DELETE, 5'd4, 5'd5);
    finish_phase();
  endtask

  task automatic test_node_range();
    send_request(MODE_INSERT, 5'd0,  5'd1);
    send_request(MODE_QUERY,  5'd11, 5'd1);
    send_request(MODE_DELETE, 5'd1,  5'd16);
    send_request(MODE_CLEAR,  5'd31, 5'd31);
    finish_phase();
  endtask

  task automatic test_counter_saturation();
    set_node_count(5'd16);
    repeat (16) send_request(MODE_INSERT, 5'd16, 5'd16);
    send_request(MODE_QUERY, 5'd16, 5'd16);
    finish_phase();
  endtask

  // random chain through all sixteen nodes, queries, then one link cut and more queries
  task automatic test_chain_queries();
    int order [GRE_MAX_NODES];
    int j;
    int tmp;
    int cut;
    set_node_count(5'd16);
    foreach (order[i]) order[i] = i + 1;
    for (int i = GRE_MAX_NODES - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i + 1 < GRE_MAX_NODES; i++)
      send_request(MODE_INSERT, NODE_W'(order[i]), NODE_W'(order[i + 1]));
    repeat (20)
      send_request(MODE_QUERY, NODE_W'(order[$urandom_range(0, 15)]),
                   NODE_W'(order[$urandom_range(0, 15)]));
    cut = $urandom_range(0, GRE_MAX_NODES - 2);
    send_request(MODE_DELETE, NODE_W'(order[cut]), NODE_W'(order[cut + 1]));
    repeat (12)
      send_request(MODE_QUERY, NODE_W'(order[$urandom_range(0, 15)]),
                   NODE_W'(order[$urandom_range(0, 15)]));
    finish_phase();
  endtask

  task automatic test_no_idle_burst();
    quiet_stretch = 1'b1;
    set_node_count(5'd16);
    run_mixed_traffic(150);
    finish_phase();
    quiet_stretch = 1'b0;
  endtask

  task automatic test_dense_small_graphs();
    set_node_count(5'd4);
    run_mixed_traffic(120);
    finish_phase();
    set_node_count(5'd2);
    run_mixed_traffic(80);
    finish_phase();
  endtask

  task automatic test_empty_and_single();
    set_node_count(5'd0);
    run_mixed_traffic(20);
    finish_phase();
    set_node_count(5'd1);
    run_mixed_traffic(40);
    finish_phase();
  endtask

  // counts above the node limit behave as the limit
  task automatic test_oversized_count();
    set_node_count(5'd31);
    run_mixed_traffic(100);
    finish_phase();
  endtask

  task automatic test_random_sizes();
    repeat (2) begin
      set_node_count(NODE_W'($urandom_range(3, 15)));
      run_mixed_traffic(120);
      finish_phase();
    end
  endtask

  initial begin
    node_count_cfg = NODE_COUNT_RST;
    clear_graph();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_default_graph();
    test_node_range();
    test_counter_saturation();
    test_chain_queries();
    test_no_idle_burst();
    test_dense_small_graphs();
    test_empty_and_single();
    test_oversized_count();
    test_random_sizes();
    wait_drained();
    repeat (400) @(posedge clk_i);
    $display("Ran %0d items across %0d node-count writes, %0d results checked.",
             items_sent, cfg_writes, results_checked);
    $display("ok/range/absent/saturated: %0d/%0d/%0d/%0d, reachable answers: %0d",
             status_seen[STS_OK], status_seen[STS_RANGE], status_seen[STS_ABSENT],
             status_seen[STS_SAT], reach_hits);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
